[design/svf_pkg.sv]
// ----------------------------------------------------------------------------
// svf_pkg
// Shared types and constants of the multimode state variable filter.
// ----------------------------------------------------------------------------
`default_nettype none

package svf_pkg;

  localparam int unsigned COEF_W = 18;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_CUTOFF  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_DAMPING = 2'd1;
  localparam logic [IDX_W-1:0] CFG_MODE    = 2'd2;

  localparam logic [COEF_W-1:0] CUTOFF_RST  = 18'd8573;
  localparam logic [COEF_W-1:0] DAMPING_RST = 18'd92682;

  typedef enum logic [1:0] {
    MODE_LOW   = 2'd0,
    MODE_HIGH  = 2'd1,
    MODE_BAND  = 2'd2,
    MODE_NOTCH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_HIGH,
    ST_MUL_HC,
    ST_BAND,
    ST_MUL_BC,
    ST_LOW,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_BAND_DAMP,
    MUL_HIGH_CUT,
    MUL_BAND_CUT
  } mul_op_t;

  typedef struct packed {
    logic    ld_x;
    mul_op_t mul_op;
    logic    ld_high;
    logic    ld_band;
    logic    ld_low;
    logic    ld_out;
  } cmd_t;

endpackage

`default_nettype wire

[design/multimode_state_variable_filter.sv]
// One item at a time: a new input is accepted only in the idle state,
//   after the previous result is loaded; the single shared coefficient
//   multiplier runs the three dependent products (damping*band,
//   cutoff*high, cutoff*band) one after another, each in a stage of its own.
// Reset (synchronous, rst_n low) clears both integrator states and loads
//   the coefficient and mode registers with their defaults.
// ----------------------------------------------------------------------------
// multimode_state_variable_filter
// Chamberlin state variable filter with selectable low/high/band/notch output.
// ----------------------------------------------------------------------------
`default_nettype none

module multimode_state_variable_filter #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned STATE_WIDTH  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [svf_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [svf_pkg::COEF_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_WIDTH:0]         out_sample_out
);

  svf_pkg::cmd_t cmd;

  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  svf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out)
  );

endmodule

`default_nettype wire

[design/svf_ctrl.sv]
// ----------------------------------------------------------------------------
// svf_ctrl
// Sequencer: steps one item through three shared multiplies and the state
// updates, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output svf_pkg::cmd_t      cmd
);

  svf_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_op    = svf_pkg::MUL_NONE;
    case (state_r)
      svf_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_x  = 1'b1;
          state_nxt = svf_pkg::ST_MUL_D;
        end
      end
      svf_pkg::ST_MUL_D: begin
        cmd.mul_op = svf_pkg::MUL_BAND_DAMP;
        state_nxt  = svf_pkg::ST_HIGH;
      end
      svf_pkg::ST_HIGH: begin
        cmd.ld_high = 1'b1;
        state_nxt   = svf_pkg::ST_MUL_HC;
      end
      svf_pkg::ST_MUL_HC: begin
        cmd.mul_op = svf_pkg::MUL_HIGH_CUT;
        state_nxt  = svf_pkg::ST_BAND;
      end
      svf_pkg::ST_BAND: begin
        cmd.ld_band = 1'b1;
        state_nxt   = svf_pkg::ST_MUL_BC;
      end
      svf_pkg::ST_MUL_BC: begin
        cmd.mul_op = svf_pkg::MUL_BAND_CUT;
        state_nxt  = svf_pkg::ST_LOW;
      end
      svf_pkg::ST_LOW: begin
        cmd.ld_low = 1'b1;
        state_nxt  = svf_pkg::ST_OUT;
      end
      svf_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = svf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svf_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == svf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // result register is only overwritten once its item has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("result overwritten while pending");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == svf_pkg::ST_MUL_D))
    else $error("accepted item did not start");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svf_pkg::ST_OUT && !cmd.ld_out) |=>
      (state_r == svf_pkg::ST_OUT && out_valid_r))
    else $error("finished item left without delivery");

endmodule

`default_nettype wire

[design/svf_datapath.sv]
// ----------------------------------------------------------------------------
// svf_datapath
// Coefficient registers, integrator states, one shared coefficient
// multiplier with rounding, saturation and output select/clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module svf_datapath #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned STATE_WIDTH  = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [svf_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [svf_pkg::COEF_W-1:0]        cfg_data,
  input  wire svf_pkg::cmd_t                     cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  output logic signed [SAMPLE_WIDTH:0]           sample_out
);

  localparam int unsigned SW = STATE_WIDTH;
  localparam int unsigned AW = ((SW > SAMPLE_WIDTH) ? SW : SAMPLE_WIDTH) + 4;
  localparam int unsigned PW = SW + svf_pkg::COEF_W + 1;
  localparam int unsigned RW = PW - 16;

  localparam logic signed [AW-1:0] ST_MAX  = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN  = ~ST_MAX;
  localparam logic signed [AW-1:0] LIM_POS =
    {{(AW-SAMPLE_WIDTH){1'b0}}, 1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [AW-1:0] LIM_NEG = -LIM_POS;
  localparam logic signed [PW-1:0] HALF_LSB = PW'(32768);

  function automatic logic signed [SW-1:0] sat_st(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v;
    if (v > ST_MAX) t = ST_MAX;
    if (v < ST_MIN) t = ST_MIN;
    return t[SW-1:0];
  endfunction

  logic [svf_pkg::COEF_W-1:0]       cutoff_r, damping_r;
  svf_pkg::mode_t                   mode_r;
  logic signed [SAMPLE_WIDTH-1:0]   x_r;
  logic signed [SW-1:0]             low_r, band_r, high_r;
  logic signed [PW-1:0]             p_r, p_nxt;
  logic signed [SAMPLE_WIDTH:0]     out_r, out_nxt;

  logic signed [SW-1:0]             mul_a;
  logic [svf_pkg::COEF_W-1:0]       mul_c;
  logic signed [PW-1:0]             p_round;
  logic signed [RW-1:0]             rnd;
  logic signed [AW-1:0]             high_sum, band_sum, low_sum, sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= svf_pkg::CUTOFF_RST;
      damping_r <= svf_pkg::DAMPING_RST;
      mode_r    <= svf_pkg::MODE_LOW;
    end else if (cfg_we) begin
      case (cfg_index)
        svf_pkg::CFG_CUTOFF:  cutoff_r  <= cfg_data;
        svf_pkg::CFG_DAMPING: damping_r <= cfg_data;
        svf_pkg::CFG_MODE:    mode_r    <= svf_pkg::mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      band_r <= '0;
    end else begin
      if (cmd.ld_band) band_r <= sat_st(band_sum);
      if (cmd.ld_low)  low_r  <= sat_st(low_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_x)    x_r    <= sample_in;
    if (cmd.ld_high) high_r <= sat_st(high_sum);
    if (cmd.ld_out)  out_r  <= out_nxt;
    p_r <= p_nxt;
  end

  always_comb begin
    mul_a = band_r;
    mul_c = cutoff_r;
    case (cmd.mul_op)
      svf_pkg::MUL_BAND_DAMP: begin
        mul_a = band_r;
        mul_c = damping_r;
      end
      svf_pkg::MUL_HIGH_CUT: begin
        mul_a = high_r;
        mul_c = cutoff_r;
      end
      svf_pkg::MUL_BAND_CUT: begin
        mul_a = band_r;
        mul_c = cutoff_r;
      end
      default: ;
    endcase
  end

  assign p_nxt = PW'(mul_a) * PW'(signed'({1'b0, mul_c}));

  // round to nearest, ties toward plus infinity
  assign p_round  = p_r + HALF_LSB;
  assign rnd      = p_round[PW-1:16];

  assign high_sum = AW'(x_r) - AW'(low_r) - AW'(rnd);
  assign band_sum = AW'(band_r) + AW'(rnd);
  assign low_sum  = AW'(low_r) + AW'(rnd);

  always_comb begin
    case (mode_r)
      svf_pkg::MODE_LOW:   sel = AW'(low_r);
      svf_pkg::MODE_HIGH:  sel = AW'(high_r);
      svf_pkg::MODE_BAND:  sel = AW'(band_r);
      svf_pkg::MODE_NOTCH: sel = AW'(high_r) + AW'(low_r);
      default:             sel = AW'(low_r);
    endcase
    out_nxt = sel[SAMPLE_WIDTH:0];
    if (sel > LIM_POS) out_nxt = LIM_POS[SAMPLE_WIDTH:0];
    if (sel < LIM_NEG) out_nxt = LIM_NEG[SAMPLE_WIDTH:0];
  end

  assign sample_out = out_r;

endmodule

`default_nettype wire
